// ----- design/mcbs_pkg.sv -----
// Package for the coin-bias Metropolis sampler: widths, request codes,
// register indexes and the word types passed between front and back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcbs_pkg;
	localparam int NUM_BINS_DEF    = 100;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int LN2_Q16         = 45426;
	localparam logic signed [31:0] LOGR_FLOOR = -32'sd19660800;

	localparam logic [1:0] REQ_STEP = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_LOAD = 2'd2;
	localparam logic [1:0] REQ_NOP  = 2'd3;

	localparam logic [1:0] REG_HEADS    = 2'd0;
	localparam logic [1:0] REG_TAILS    = 2'd1;
	localparam logic [1:0] REG_WINDOW   = 2'd2;
	localparam logic [1:0] REG_INTERVAL = 2'd3;

	// decoded request word handed from front to back
	typedef struct packed {
		logic [1:0]  req;
		logic [15:0] rand_propose;
		logic [15:0] rand_accept;
		logic [6:0]  bin_index;
		logic [15:0] start_value;
	} req_word_t;
endpackage
`default_nettype wire

// ----- design/mcbs_ln.sv -----
// Iterative natural-log unit: one squaring step per cycle, 16 steps for
// log2 then one multiply by ln 2. Depends on mcbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcbs_ln (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [16:0]         x,
	output logic                     done,
	output logic signed [31:0]       result
);
	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_SQR  = 3'b010,
		L_MUL  = 3'b100
	} ln_state_t;

	ln_state_t   state_q;
	logic [31:0] m_q;
	logic [15:0] frac_q;
	logic [4:0]  e_q;
	logic [3:0]  step_q;
	logic [16:0] xc;
	logic [4:0]  e_c;
	logic [63:0] sq;
	logic [32:0] sqs;
	logic [31:0] mag;
	logic [47:0] prod;

	always_comb begin
		xc = (x == 17'd0) ? 17'd1 : ((x > 17'h10000) ? 17'h10000 : x);
		e_c = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (xc[i]) begin
				e_c = 5'(i);
			end
		end
		sq  = 64'(m_q) * 64'(m_q);
		sqs = 33'(sq >> 30);
		mag = (e_q == 5'd16) ? 32'd0 : (32'((16 - 32'(e_q)) << 16) - 32'(frac_q));
		prod = 48'(mag) * 48'(mcbs_pkg::LN2_Q16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_SQR;
						m_q     <= 32'({15'd0, xc} << (30 - 32'(e_c)));
						e_q     <= e_c;
						frac_q  <= '0;
						step_q  <= 4'd15;
					end
				end
				L_SQR: begin
					if (sqs[31] || sqs[32]) begin
						m_q <= 32'(sqs >> 1);
						frac_q[step_q] <= 1'b1;
					end else begin
						m_q <= sqs[31:0];
					end
					if (step_q == 4'd0) begin
						state_q <= L_MUL;
					end
					step_q <= step_q - 4'd1;
				end
				L_MUL: begin
					result  <= -32'(signed'({1'b0, 31'((prod + 48'd32768) >> 16)}));
					done    <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/mcbs_front.sv -----
// Front end: accepts request words and holds them in a short queue for
// the back end. Depends on mcbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcbs_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire mcbs_pkg::req_word_t  in_word,
	output logic                      q_valid,
	input  wire logic                 q_pop,
	output mcbs_pkg::req_word_t       q_word
);
	mcbs_pkg::req_word_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_word   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) !q_valid |-> !(q_pop && q_valid))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !(q_pop && q_valid)) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count lost a push");
endmodule
`default_nettype wire

// ----- design/mcbs_back.sv -----
// Back end: runs one request to completion (step, bin read, load, no-op),
// with a shared log unit and the histogram memory. Depends on mcbs_pkg, mcbs_ln.
`timescale 1ns / 1ps
`default_nettype none
module mcbs_back #(
	parameter int NUM_BINS    = mcbs_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = mcbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_pop,
	input  wire mcbs_pkg::req_word_t q_word,
	input  wire logic [15:0]         heads_count,
	input  wire logic [15:0]         tails_count,
	input  wire logic [15:0]         window_width,
	input  wire logic [15:0]         sample_interval,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [15:0]              o_theta,
	output logic [15:0]              o_proposal,
	output logic                     o_accepted,
	output logic                     o_sampled,
	output logic [31:0]              o_bin_count,
	output logic [31:0]              o_samples_total
);
	localparam int BW = $clog2(NUM_BINS);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_PROP  = 11'b00000000010,
		S_LN    = 11'b00000000100,
		S_LNW   = 11'b00000001000,
		S_MUL   = 11'b00000010000,
		S_SUM   = 11'b00000100000,
		S_DEC   = 11'b00001000000,
		S_IDX   = 11'b00010000000,
		S_BIN   = 11'b00100000000,
		S_RMW   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} bk_state_t;

	bk_state_t            state_q;
	mcbs_pkg::req_word_t  w_q;
	logic [15:0]          theta_q, prop_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [15:0]          phase_q;
	logic [COUNT_WIDTH-1:0] hist_q [NUM_BINS];
	logic [NUM_BINS-1:0]  hvalid_q;
	logic [COUNT_WIDTH-1:0] rd_q;
	logic [BW-1:0]        bin_q;
	logic [2:0]           lnsel_q;
	logic signed [31:0]   ln_q [5];
	logic signed [63:0]   ph_q, pt_q;
	logic signed [63:0]   logr_q;
	logic                 acc_q, smp_q;
	logic                 ln_start, ln_done;
	logic [16:0]          ln_x;
	logic signed [31:0]   ln_r;
	logic signed [33:0]   prod;
	logic signed [17:0]   off;
	logic signed [18:0]   p;
	logic signed [31:0]   logr_sat;
	logic [15:0]          ivl;
	logic [15+8:0]        bmul;
	logic                 out_load;

	mcbs_ln u_ln (.clk(clk), .arst_n(arst_n), .start(ln_start), .x(ln_x),
		.done(ln_done), .result(ln_r));

	always_comb begin
		prod = $signed({1'b0, w_q.rand_propose} - 17'sd32768) * $signed({1'b0, window_width});
		// floor toward minus infinity of prod / 2^16 (arith shift)
		off = 18'(prod >>> 16);
		p = 19'(signed'({3'b0, theta_q})) + 19'(off);
		if (p < 0) p = -p;
		else if (p > 19'sd65536) p = 19'sd131072 - p;
		if (p > 19'sd65535) p = 19'sd65535;
		unique case (lnsel_q)
			3'd0: ln_x = {1'b0, prop_q};
			3'd1: ln_x = {1'b0, theta_q};
			3'd2: ln_x = 17'h10000 - {1'b0, prop_q};
			3'd3: ln_x = 17'h10000 - {1'b0, theta_q};
			default: ln_x = {1'b0, w_q.rand_accept};
		endcase
		ln_start = (state_q == S_LN);
		logr_sat = (logr_q > 64'sd2147483647) ? 32'h7fffffff :
			((logr_q < -64'sd2147483648) ? 32'h80000000 : 32'(logr_q));
		ivl  = (sample_interval == 16'd0) ? 16'd1 : sample_interval;
		bmul = 24'(theta_q) * 24'(NUM_BINS);
		q_pop = (state_q == S_IDLE) && q_valid;
		out_load = (state_q == S_OUT) && (!out_valid || out_ready);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RMW && smp_q) begin
			hist_q[bin_q] <= (!hvalid_q[bin_q]) ? COUNT_WIDTH'(1) :
				((rd_q == CMAX) ? CMAX : rd_q + 1'b1);
		end
		if (state_q == S_BIN) begin
			rd_q <= hist_q[bin_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			theta_q   <= '0;
			total_q   <= '0;
			phase_q   <= '0;
			hvalid_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						w_q <= q_word;
						acc_q <= 1'b0; smp_q <= 1'b0; prop_q <= '0;
						unique case (q_word.req)
							mcbs_pkg::REQ_STEP: state_q <= S_PROP;
							mcbs_pkg::REQ_READ: begin
								bin_q   <= BW'(q_word.bin_index);
								state_q <= (32'(q_word.bin_index) < NUM_BINS) ? S_BIN : S_OUT;
							end
							mcbs_pkg::REQ_LOAD: begin
								theta_q <= q_word.start_value;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_PROP: begin
					prop_q  <= 16'(p);
					lnsel_q <= 3'd0;
					state_q <= S_LN;
				end
				S_LN: state_q <= S_LNW;
				S_LNW: begin
					if (ln_done) begin
						ln_q[lnsel_q] <= ln_r;
						if (lnsel_q == 3'd4) begin
							state_q <= S_DEC;
						end else if (lnsel_q == 3'd3) begin
							state_q <= S_MUL;
						end else begin
							lnsel_q <= lnsel_q + 3'd1;
							state_q <= S_LN;
						end
					end
				end
				S_MUL: begin
					ph_q <= 64'(signed'({1'b0, heads_count})) * 64'(ln_q[0] - ln_q[1]);
					pt_q <= 64'(signed'({1'b0, tails_count})) * 64'(ln_q[2] - ln_r);
					state_q <= S_SUM;
				end
				S_SUM: begin
					logr_q  <= ph_q + pt_q;
					lnsel_q <= 3'd4;
					state_q <= S_LN;
				end
				S_DEC: begin
					if (logr_sat < mcbs_pkg::LOGR_FLOOR) acc_q <= 1'b0;
					else if (logr_sat > 0) acc_q <= 1'b1;
					else acc_q <= (w_q.rand_accept == 16'd0) || (ln_r < logr_sat);
					if (!(logr_sat < mcbs_pkg::LOGR_FLOOR) &&
						((logr_sat > 0) || (w_q.rand_accept == 16'd0) || (ln_r < logr_sat)))
						theta_q <= prop_q;
					if ({1'b0, phase_q} + 17'd1 >= {1'b0, ivl}) begin
						phase_q <= '0;
						smp_q   <= 1'b1;
						total_q <= (total_q == CMAX) ? CMAX : total_q + 1'b1;
					end else begin
						phase_q <= phase_q + 16'd1;
					end
					state_q <= S_IDX;
				end
				S_IDX: begin
					// bin of the updated theta, clamped to the last bin
					bin_q <= (bmul[23:16] > 8'(NUM_BINS - 1)) ? BW'(NUM_BINS - 1) :
						BW'(bmul[23:16]);
					state_q <= S_BIN;
				end
				S_BIN: begin
					state_q <= (w_q.req == mcbs_pkg::REQ_STEP) ? S_RMW : S_OUT;
				end
				S_RMW: begin
					if (smp_q && !hvalid_q[bin_q]) begin
						hvalid_q[bin_q] <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						o_theta         <= theta_q;
						o_proposal      <= prop_q;
						o_accepted      <= acc_q;
						o_sampled       <= smp_q;
						o_bin_count     <= (w_q.req == mcbs_pkg::REQ_READ &&
							hvalid_q[bin_q] && 32'(w_q.bin_index) < NUM_BINS) ?
							32'(rd_q) : 32'd0;
						o_samples_total <= 32'(total_q);
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!out_valid || out_ready)) |=> out_valid)
		else $error("result word not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE)
		else $error("request popped while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LNW |-> lnsel_q <= 3'd4)
		else $error("log operand select out of range");
endmodule
`default_nettype wire

// ----- design/metropolis_coin_bias_sampler_core.sv -----
// Top level of the coin-bias Metropolis sampler: config registers, front
// queue and back end. Depends on mcbs_pkg, mcbs_front, mcbs_back.
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata {start,bin,acc,prop}, tuser req_type
// m_axis    out  m_axis_tvalid/tready       tdata {total,bin,smp,acc,prop,theta}
// apb       in   psel/penable/pwrite/pready paddr/pwdata/prdata
//
// A chain step holds the back end for five passes of the shared log unit
// (each: start, 16 squarings, multiply, handoff) plus pop, propose, multiply,
// sum, decide, bin index, bin read, update and output. In-range bin reads
// go pop, bin read, output; loads, no-ops and out-of-range reads pop, output.
// Reset clears theta, counters and histogram valid bits at once.
// A two-word queue keeps input accepting while the back end works, until it
// is full; a held result word stalls the back end in its output state.
`timescale 1ns / 1ps
`default_nettype none
module metropolis_coin_bias_sampler_core #(
	parameter int NUM_BINS    = mcbs_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = mcbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: rand_propose[15:0], rand_accept[31:16], bin_index[38:32],
	// start_value[54:39], zero pad
	input  wire logic [55:0]  s_axis_tdata,
	// tuser: req_type[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: current_theta[15:0], proposal[31:16], accepted[32], sampled[33],
	// bin_count[65:34], samples_total[97:66], zero pad
	output logic [103:0]      m_axis_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	logic [15:0] heads_q, tails_q, window_q, interval_q;
	mcbs_pkg::req_word_t in_word, q_word;
	logic q_valid, q_pop;
	logic [15:0] o_theta, o_proposal;
	logic o_accepted, o_sampled;
	logic [31:0] o_bin_count, o_samples_total;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// hold registers; write on access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heads_q <= 16'd43; tails_q <= 16'd57;
			window_q <= 16'd8192; interval_q <= 16'd1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			unique case (reg_idx)
				mcbs_pkg::REG_HEADS:    heads_q    <= pwdata[15:0];
				mcbs_pkg::REG_TAILS:    tails_q    <= pwdata[15:0];
				mcbs_pkg::REG_WINDOW:   window_q   <= pwdata[15:0];
				default:                interval_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mcbs_pkg::REG_HEADS:  prdata = {16'd0, heads_q};
			mcbs_pkg::REG_TAILS:  prdata = {16'd0, tails_q};
			mcbs_pkg::REG_WINDOW: prdata = {16'd0, window_q};
			default:              prdata = {16'd0, interval_q};
		endcase
		in_word.req          = s_axis_tuser;
		in_word.rand_propose = s_axis_tdata[15:0];
		in_word.rand_accept  = s_axis_tdata[31:16];
		in_word.bin_index    = s_axis_tdata[38:32];
		in_word.start_value  = s_axis_tdata[54:39];
	end

	mcbs_front u_front (.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .in_word(in_word), .q_valid(q_valid),
		.q_pop(q_pop), .q_word(q_word));

	mcbs_back #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_word(q_word), .heads_count(heads_q), .tails_count(tails_q),
		.window_width(window_q), .sample_interval(interval_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.o_theta(o_theta), .o_proposal(o_proposal), .o_accepted(o_accepted),
		.o_sampled(o_sampled), .o_bin_count(o_bin_count),
		.o_samples_total(o_samples_total));

	assign m_axis_tdata = {6'd0, o_samples_total, o_bin_count, o_sampled,
		o_accepted, o_proposal, o_theta};
endmodule
`default_nettype wire
